// ===== rtl/assert_macros.svh =====
// Assertion helpers for the checker file.
// Each expects signals named clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, silent while reset is asserted.
`define FODS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stencil check failed");

// Next-cycle implication, silent while reset is asserted.
`define FODS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stencil check failed");

// Condition that must hold on the cycle after a reset edge.
`define FODS_ASSERT_RST(lbl, cons) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("stencil reset check failed");

`endif

// ===== rtl/fods_pkg.sv =====
package fods_pkg;

  localparam int SAMPLE_BITS = 32;
  localparam int MAX_POINTS  = 4096;
  localparam int MAX_VARS    = 8;
  localparam int MIN_POINTS  = 5;
  localparam int TAPS        = 5;
  localparam int HIST_TAPS   = TAPS - 1;

  localparam int DERIV_W     = 36;
  localparam int PT_W        = 12;
  localparam int VAR_W       = 3;
  localparam int WT_W        = 7;

  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 1;
  localparam int LP_REG_W    = 13;
  localparam int NV_REG_W    = 4;

  localparam int IN_DATA_W   = 32;
  localparam int OUT_USED_W  = DERIV_W + PT_W + VAR_W;
  localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_POINTS = 1'd0,
    REG_NUM_VARS    = 1'd1
  } cfg_reg_t;

  // Order matches the bit order of the back end's pending-result mask.
  typedef enum logic [2:0] {
    STC_LEFT0  = 3'd0,
    STC_LEFT1  = 3'd1,
    STC_CENTER = 3'd2,
    STC_RIGHT1 = 3'd3,
    STC_RIGHT0 = 3'd4
  } stencil_t;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // One classified point: five-sample window (oldest in taps[0]) plus
  // what the back end needs to emit its results.
  typedef struct packed {
    sample_t [TAPS-1:0] taps;
    logic [PT_W-1:0]    pt_c;      // center point index, p - 2
    logic [VAR_W-1:0]   var_idx;
    logic               first;     // left boundary results due
    logic               tail;      // right boundary results due
    logic               line_end;  // tail of the last variable
  } work_t;

  // Weights per tap, tap 0 oldest.
  function automatic logic [TAPS-1:0][WT_W-1:0] stencil_weights(input stencil_t s);
    logic [TAPS-1:0][WT_W-1:0] w;
    case (s)
      STC_LEFT0: begin
        w[0] = WT_W'(-25); w[1] = WT_W'(48);  w[2] = WT_W'(-36);
        w[3] = WT_W'(16);  w[4] = WT_W'(-3);
      end
      STC_LEFT1: begin
        w[0] = WT_W'(-3);  w[1] = WT_W'(-10); w[2] = WT_W'(18);
        w[3] = WT_W'(-6);  w[4] = WT_W'(1);
      end
      STC_CENTER: begin
        w[0] = WT_W'(1);   w[1] = WT_W'(-8);  w[2] = WT_W'(0);
        w[3] = WT_W'(8);   w[4] = WT_W'(-1);
      end
      STC_RIGHT1: begin
        w[0] = WT_W'(-1);  w[1] = WT_W'(6);   w[2] = WT_W'(-18);
        w[3] = WT_W'(10);  w[4] = WT_W'(3);
      end
      STC_RIGHT0: begin
        w[0] = WT_W'(3);   w[1] = WT_W'(-16); w[2] = WT_W'(36);
        w[3] = WT_W'(-48); w[4] = WT_W'(25);
      end
      default: begin
        w = '0;
      end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/fods_front.sv =====
module fods_front #(
  parameter int MAX_POINTS = fods_pkg::MAX_POINTS,
  parameter int MAX_VARS   = fods_pkg::MAX_VARS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [fods_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fods_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [fods_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                             wk_valid,
  input  logic                             wk_ready,
  output fods_pkg::work_t                  wk_data
);
  import fods_pkg::*;

  localparam int PW = $clog2(MAX_POINTS);
  localparam int VW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;

  logic [PW-1:0] last_pt_r, pcnt_r, pcnt_nxt, lp_last;
  logic [VW-1:0] last_var_r, vcnt_r, vcnt_nxt, nv_last;
  sample_t       hist_r [MAX_VARS][HIST_TAPS];
  sample_t       row [HIST_TAPS];
  sample_t       x;
  logic          accept;
  int            lp, nv;

  // Clamp register writes to their usable range.
  always_comb begin
    lp = int'(cfg_wdata[LP_REG_W-1:0]);
    if (lp < MIN_POINTS) lp = MIN_POINTS;
    if (lp > MAX_POINTS) lp = MAX_POINTS;
    lp_last = PW'(lp - 1);
    nv = int'(cfg_wdata[NV_REG_W-1:0]);
    if (nv < 1) nv = 1;
    if (nv > MAX_VARS) nv = MAX_VARS;
    nv_last = VW'(nv - 1);
  end

  always_comb begin
    in_tready = wk_ready;
    accept    = in_tvalid && in_tready;
    x         = $signed(in_tdata[SAMPLE_BITS-1:0]);
    for (int k = 0; k < HIST_TAPS; k++) begin
      row[k] = hist_r[vcnt_r][k];
    end
    for (int k = 0; k < HIST_TAPS; k++) begin
      wk_data.taps[k] = row[k];
    end
    wk_data.taps[TAPS-1] = x;
    wk_data.pt_c     = PT_W'(pcnt_r - PW'(2));
    wk_data.var_idx  = VAR_W'(vcnt_r);
    wk_data.first    = (pcnt_r == PW'(4));
    wk_data.tail     = (pcnt_r == last_pt_r);
    wk_data.line_end = (pcnt_r == last_pt_r) && (vcnt_r == last_var_r);
    wk_valid = accept && (pcnt_r >= PW'(4));

    if (vcnt_r == last_var_r) begin
      vcnt_nxt = '0;
      pcnt_nxt = (pcnt_r == last_pt_r) ? '0 : pcnt_r + PW'(1);
    end else begin
      vcnt_nxt = vcnt_r + VW'(1);
      pcnt_nxt = pcnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pt_r  <= PW'(MIN_POINTS - 1);
      last_var_r <= '0;
      pcnt_r     <= '0;
      vcnt_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LINE_POINTS: last_pt_r  <= lp_last;
        REG_NUM_VARS:    last_var_r <= nv_last;
        default: ;
      endcase
      // Any write restarts the line.
      pcnt_r <= '0;
      vcnt_r <= '0;
    end else if (accept) begin
      pcnt_r <= pcnt_nxt;
      vcnt_r <= vcnt_nxt;
    end
  end

  // Shift the selected variable's delay line.
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < HIST_TAPS - 1; k++) begin
        hist_r[vcnt_r][k] <= row[k+1];
      end
      hist_r[vcnt_r][HIST_TAPS-1] <= x;
    end
  end

endmodule

// ===== rtl/fods_queue.sv =====
module fods_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  fods_pkg::work_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output fods_pkg::work_t pop_data
);
  import fods_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  work_t         mem_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   count_r;
  logic          push, pop;

  always_comb begin
    push_ready = (count_r != (AW+1)'(QUEUE_DEPTH));
    pop_valid  = (count_r != '0);
    pop_data   = mem_r[rd_ptr_r];
    push       = push_valid && push_ready;
    pop        = pop_valid && pop_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + AW'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + (AW+1)'(1);
        2'b01:   count_r <= count_r - (AW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

// ===== rtl/fods_back.sv =====
module fods_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wk_valid,
  output logic                            wk_ready,
  input  fods_pkg::work_t                 wk_data,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [fods_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  output logic                            out_tuser
);
  import fods_pkg::*;

  localparam int    PROD_W   = SAMPLE_BITS + WT_W;
  localparam int    SUM_W    = SAMPLE_BITS + 8;
  localparam int    M_W      = SUM_W - 2;
  localparam int    SPLIT    = 18;
  localparam int    MH_W     = M_W - SPLIT;
  localparam int    X_W      = MH_W + 1;
  localparam int    K        = (X_W % 2 == 1) ? X_W : X_W + 1;
  localparam longint SPLIT_DIV3 = ((longint'(1) << SPLIT) - 1) / 3;
  localparam longint RECIP3     = ((longint'(1) << K) + 1) / 3;
  localparam int    P1_W     = MH_W + SPLIT - 1;
  localparam int    XC_W     = X_W + K;
  localparam int    Q_W      = ((P1_W > X_W) ? P1_W : X_W) + 1;
  localparam int    PAD_W    = OUT_DATA_W - OUT_USED_W;

  typedef struct packed {
    logic [PT_W-1:0]  pt;
    logic [VAR_W-1:0] var_idx;
    logic             run_last;
    logic             line_done;
  } meta_t;

  // Sequencer state
  logic [TAPS-1:0] mask_r, mask_nxt, init_mask, cur_mask, sel, rem;
  logic            busy_r, busy_nxt, found, issue, advance;
  stencil_t        stc;
  meta_t           meta0;
  logic [TAPS-1:0][WT_W-1:0] wts;
  logic signed [PROD_W-1:0] prod [TAPS];

  // Pipeline
  logic                     s1_v_r, s2_v_r, s3_v_r, s4_v_r, s5_v_r, out_v_r;
  logic signed [PROD_W-1:0] s1_prod_r [TAPS];
  meta_t                    s1_meta_r, s2_meta_r, s3_meta_r, s4_meta_r, s5_meta_r, out_meta_r;
  logic signed [SUM_W-1:0]  s2_sum_r, sum_nxt;
  logic [SUM_W-1:0]         a_nxt;
  logic [M_W-1:0]           s3_m_r;
  logic                     s3_neg_r, s4_neg_r, s5_neg_r;
  logic [MH_W-1:0]          s4_mh_r;
  logic [X_W-1:0]           s4_x_r;
  logic [P1_W-1:0]          s5_p1_r;
  logic [X_W-1:0]           s5_p2_r;
  logic [XC_W-1:0]          xc;
  logic [Q_W-1:0]           q;
  logic [DERIV_W-1:0]       out_deriv_r, deriv_nxt;

  assign advance = !out_v_r || out_tready;

  // Pick the lowest pending result of the head item.
  always_comb begin
    init_mask = {wk_data.tail, wk_data.tail, 1'b1, wk_data.first, wk_data.first};
    cur_mask  = busy_r ? mask_r : init_mask;
    sel       = '0;
    found     = 1'b0;
    stc       = STC_CENTER;
    for (int k = 0; k < TAPS; k++) begin
      if (cur_mask[k] && !found) begin
        sel[k] = 1'b1;
        found  = 1'b1;
        stc    = stencil_t'(3'(k));
      end
    end
    rem      = cur_mask & ~sel;
    issue    = wk_valid && advance;
    wk_ready = advance && (rem == '0);

    meta0.var_idx   = wk_data.var_idx;
    meta0.run_last  = (rem == '0);
    meta0.line_done = (rem == '0) && wk_data.line_end;
    case (stc)
      STC_LEFT0:  meta0.pt = '0;
      STC_LEFT1:  meta0.pt = PT_W'(1);
      STC_CENTER: meta0.pt = wk_data.pt_c;
      STC_RIGHT1: meta0.pt = wk_data.pt_c + PT_W'(1);
      STC_RIGHT0: meta0.pt = wk_data.pt_c + PT_W'(2);
      default:    meta0.pt = wk_data.pt_c;
    endcase

    busy_nxt = busy_r;
    mask_nxt = mask_r;
    if (issue) begin
      busy_nxt = (rem != '0);
      mask_nxt = rem;
    end

    wts = stencil_weights(stc);
    for (int k = 0; k < TAPS; k++) begin
      prod[k] = PROD_W'($signed(wk_data.taps[k])) * PROD_W'($signed(wts[k]));
    end
  end

  // Sum, then round-half-away division by 12: floor((|s|+6)/4) / 3, the /3 split
  // into a high part times (2^SPLIT-1)/3 plus a reciprocal multiply on the rest.
  always_comb begin
    sum_nxt = '0;
    for (int k = 0; k < TAPS; k++) begin
      sum_nxt = sum_nxt + SUM_W'(s1_prod_r[k]);
    end
    a_nxt = s2_sum_r[SUM_W-1] ? (~s2_sum_r + SUM_W'(7)) : (s2_sum_r + SUM_W'(6));
    xc    = XC_W'(s4_x_r) * XC_W'(RECIP3);
    q     = Q_W'(s5_p1_r) + Q_W'(s5_p2_r);
    deriv_nxt = s5_neg_r ? DERIV_W'(~q + Q_W'(1)) : DERIV_W'(q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      mask_r  <= '0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      s5_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      mask_r <= mask_nxt;
      if (advance) begin
        s1_v_r  <= issue;
        s2_v_r  <= s1_v_r;
        s3_v_r  <= s2_v_r;
        s4_v_r  <= s3_v_r;
        s5_v_r  <= s4_v_r;
        out_v_r <= s5_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < TAPS; k++) begin
        s1_prod_r[k] <= prod[k];
      end
      s1_meta_r   <= meta0;
      s2_sum_r    <= sum_nxt;
      s2_meta_r   <= s1_meta_r;
      s3_m_r      <= a_nxt[SUM_W-1:2];
      s3_neg_r    <= s2_sum_r[SUM_W-1];
      s3_meta_r   <= s2_meta_r;
      s4_mh_r     <= s3_m_r[M_W-1:SPLIT];
      s4_x_r      <= X_W'(s3_m_r[M_W-1:SPLIT]) + X_W'(s3_m_r[SPLIT-1:0]);
      s4_neg_r    <= s3_neg_r;
      s4_meta_r   <= s3_meta_r;
      s5_p1_r     <= P1_W'(s4_mh_r) * P1_W'(SPLIT_DIV3);
      s5_p2_r     <= xc[XC_W-1:K];
      s5_neg_r    <= s4_neg_r;
      s5_meta_r   <= s4_meta_r;
      out_deriv_r <= deriv_nxt;
      out_meta_r  <= s5_meta_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_meta_r.var_idx, out_meta_r.pt, out_deriv_r};
  assign out_tlast  = out_meta_r.run_last;
  assign out_tuser  = out_meta_r.line_done;

endmodule

// ===== rtl/fourth_order_first_derivative_stencil.sv =====
// Fourth-order first-derivative stencil over one streamed grid line.
// Throughput: one sample beat per cycle while the queue has room; result beats leave one per
// cycle while out_tready is high. Path: an accepted sample passes the queue write, issue,
// sum, round, split, reciprocal multiply and output register before its first result beat; a
// boundary item emits up to 5 beats back to back, and the 4-entry queue buffers items meanwhile.
// Reset (rst_n low, synchronous): counters restart the line, line_points = 5, num_vars = 1.
module fourth_order_first_derivative_stencil #(
  parameter int MAX_POINTS = fods_pkg::MAX_POINTS,
  parameter int MAX_VARS   = fods_pkg::MAX_VARS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration writes: index 0 line_points, index 1 num_vars
  input  logic                            cfg_we,
  input  logic [fods_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fods_pkg::CFG_W-1:0]      cfg_wdata,
  // Sample stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [fods_pkg::IN_DATA_W-1:0]  in_tdata,   // [31:0] sample
  // Derivative stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [fods_pkg::OUT_DATA_W-1:0] out_tdata,  // [35:0] deriv, [47:36] point_index,
                                                      // [50:48] var_index, [55:51] zero
  output logic                            out_tlast,  // run_last
  output logic                            out_tuser   // [0] line_done
);
  import fods_pkg::*;

  // Front to queue, queue to back
  logic  fq_valid, fq_ready;
  work_t fq_data;
  logic  qb_valid, qb_ready;
  work_t qb_data;

  // Front end: track point and variable, shift the per-variable delay line
  // (flip-flop rows, one per variable), and tag which results each point owes.
  // Points before the fifth of the line only prime the delay line and push nothing.
  fods_front #(
    .MAX_POINTS (MAX_POINTS),
    .MAX_VARS   (MAX_VARS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .wk_valid  (fq_valid),
    .wk_ready  (fq_ready),
    .wk_data   (fq_data)
  );

  // Short queue decouples sample intake from the burst of boundary results.
  fods_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_data  (fq_data),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_data   (qb_data)
  );

  // Back end: walk each queued point's owed stencils in ascending point order,
  // one per cycle, through a stall-together pipeline ending in the output register.
  fods_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .wk_valid   (qb_valid),
    .wk_ready   (qb_ready),
    .wk_data    (qb_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

// ===== rtl/fods_checker.sv =====
`include "assert_macros.svh"

module fods_props (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [fods_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            out_tlast,
  input logic                            out_tuser
);

  // Hold a stalled result beat.
  `FODS_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // Hold the side flags of a stalled beat as well.
  `FODS_ASSERT_NXT(a_side_hold, out_tvalid && !out_tready, $stable({out_tlast, out_tuser}))

  // The end-of-line beat is always the last beat of its sample.
  `FODS_ASSERT_IMP(a_done_is_last, out_tvalid && out_tuser, out_tlast)

  // Drop any result in flight on reset.
  `FODS_ASSERT_RST(a_rst_no_out, !out_tvalid)

  // Queue comes out of reset empty, so intake is open.
  `FODS_ASSERT_RST(a_rst_ready, in_tready)

endmodule

bind fourth_order_first_derivative_stencil fods_props u_fods_props (.*);

// ===== tb/fods_checker.sv =====
module fods_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fods_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fods_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [fods_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [fods_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            out_tlast,
  input  logic                            out_tuser,
  output int                              fail_count,
  output int                              pending,
  output int                              samples_seen,
  output int                              derivs_seen,
  output int                              lines_seen
);
  import fods_pkg::*;

  localparam longint DERIV_HI = (longint'(1) << (DERIV_W - 1)) - 1;
  localparam longint DERIV_LO = -DERIV_HI - 1;
  localparam int     REPORT_MAX = 10;

  typedef logic signed [DERIV_W-1:0] deriv_t;

  typedef struct packed {
    deriv_t           deriv;
    logic [PT_W-1:0]  pt;
    logic [VAR_W-1:0] vr;
    logic             run_last;
    logic             line_done;
  } deriv_beat_t;

  deriv_beat_t deriv_q[$];

  // Five-point window per variable, [0] oldest
  sample_t             window [MAX_VARS][TAPS];
  logic [LP_REG_W-1:0] lp_reg;
  logic [NV_REG_W-1:0] nv_reg;
  logic [PT_W-1:0]     pt_cnt;
  logic [VAR_W-1:0]    var_cnt;

  int          pts, nvars, p, v, n_due, n_made;
  bit          line_end;
  deriv_beat_t got, want;

  function automatic deriv_t stencil_value(input stencil_t kind, input int vi);
    longint w [TAPS];
    longint acc;
    longint q;
    case (kind)
      STC_LEFT0:  w = '{-25, 48, -36, 16, -3};
      STC_LEFT1:  w = '{-3, -10, 18, -6, 1};
      STC_CENTER: w = '{1, -8, 0, 8, -1};
      STC_RIGHT1: w = '{-1, 6, -18, 10, 3};
      default:    w = '{3, -16, 36, -48, 25};
    endcase
    acc = 0;
    for (int k = 0; k < TAPS; k++) acc += w[k] * longint'(window[vi][k]);
    // round half away from zero
    if (acc >= 0) q = (acc + 6) / 12;
    else q = -((-acc + 6) / 12);
    if (q > DERIV_HI) q = DERIV_HI;
    if (q < DERIV_LO) q = DERIV_LO;
    return deriv_t'(q);
  endfunction

  function automatic void add_deriv(input stencil_t kind, input int pt);
    deriv_beat_t b;
    b.deriv     = stencil_value(kind, v);
    b.pt        = PT_W'(pt);
    b.vr        = VAR_W'(v);
    b.run_last  = (n_made == n_due - 1);
    b.line_done = b.run_last && line_end;
    deriv_q.push_back(b);
    n_made++;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      lp_reg       = LP_REG_W'(MIN_POINTS);
      nv_reg       = NV_REG_W'(1);
      pt_cnt       = '0;
      var_cnt      = '0;
      deriv_q.delete();
      fail_count   = 0;
      samples_seen = 0;
      derivs_seen  = 0;
      lines_seen   = 0;
    end else begin
      // check the result beat first: it never stems from a sample of this edge
      if (out_tvalid && out_tready) begin
        {got.vr, got.pt, got.deriv} = out_tdata[OUT_USED_W-1:0];
        got.run_last  = out_tlast;
        got.line_done = out_tuser;
        derivs_seen++;
        if (got.line_done) lines_seen++;
        if (deriv_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("unexpected beat: deriv %0d point %0d var %0d last %0b done %0b",
                     got.deriv, got.pt, got.vr, got.run_last, got.line_done);
        end else begin
          want = deriv_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("mismatch: exp deriv %0d pt %0d var %0d last %0b done %0b | got deriv %0d pt %0d var %0d last %0b done %0b",
                       want.deriv, want.pt, want.vr, want.run_last, want.line_done,
                       got.deriv, got.pt, got.vr, got.run_last, got.line_done);
          end
        end
      end

      // any register write restarts the line, history kept
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_LINE_POINTS: lp_reg = cfg_wdata[LP_REG_W-1:0];
          REG_NUM_VARS:    nv_reg = cfg_wdata[NV_REG_W-1:0];
          default: ;
        endcase
        pt_cnt  = '0;
        var_cnt = '0;
      end

      if (in_tvalid && in_tready) begin
        samples_seen++;
        pts   = int'(lp_reg);
        nvars = int'(nv_reg);
        if (pts < MIN_POINTS) pts = MIN_POINTS;
        if (pts > MAX_POINTS) pts = MAX_POINTS;
        if (nvars < 1) nvars = 1;
        if (nvars > MAX_VARS) nvars = MAX_VARS;
        if (int'(pt_cnt) >= pts) pt_cnt = '0;
        if (int'(var_cnt) >= nvars) var_cnt = '0;
        p = int'(pt_cnt);
        v = int'(var_cnt);

        for (int k = 0; k < TAPS - 1; k++) window[v][k] = window[v][k+1];
        window[v][TAPS-1] = sample_t'(in_tdata);

        n_due    = (p == 4 ? 2 : 0) + (p >= 4 ? 1 : 0) + (p == pts - 1 ? 2 : 0);
        n_made   = 0;
        line_end = (p == pts - 1) && (v == nvars - 1);
        if (p == 4) begin
          add_deriv(STC_LEFT0, 0);
          add_deriv(STC_LEFT1, 1);
        end
        if (p >= 4) add_deriv(STC_CENTER, p - 2);
        if (p == pts - 1) begin
          add_deriv(STC_RIGHT1, p - 1);
          add_deriv(STC_RIGHT0, p);
        end

        if (v + 1 >= nvars) begin
          var_cnt = '0;
          pt_cnt  = (p + 1 >= pts) ? '0 : PT_W'(p + 1);
        end else begin
          var_cnt = VAR_W'(v + 1);
        end
      end
      pending = deriv_q.size();
    end
  end

endmodule

// ===== tb/tb_fourth_order_first_derivative_stencil.sv =====
module tb_fourth_order_first_derivative_stencil;
  import fods_pkg::*;

  // Extra idle time in settle() after every expected result is out.
  localparam int DRAIN_CYCLES = 24;
  localparam int ITEM_TARGET  = 260;
  // Worst case is far below this: at most 451 samples, each with a long gap plus
  // five results that each wait out a long receive stall.
  localparam int CYCLE_LIMIT  = 1_000_000;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata  = '0;   // [31:0] sample
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // [35:0] deriv, [47:36] point_index,
                                           // [50:48] var_index, [55:51] zero
  logic                  out_tlast;        // run_last
  logic                  out_tuser;        // [0] line_done

  int fail_count, pending, samples_seen, derivs_seen, lines_seen;

  // Stimulus bookkeeping
  int          items_sent = 0;
  int          cycles     = 0;
  bit          no_idle    = 1'b0;   // sender runs back to back
  bit          stall_off  = 1'b0;   // receiver always ready
  int          ready_hold = 0;
  int          ready_roll;
  int          roll, per_line, beats_planned, nib;
  bit          wr_lp, wr_nv;
  logic [12:0] lp_w, nv_w;
  logic [12:0] lp_shadow = 13'd5;
  logic [12:0] nv_shadow = 13'd1;

  // Corner lines: full-scale alternation, then rounding ties of both signs
  logic [31:0] alt_line [5] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                32'h8000_0000, 32'h7FFF_FFFF};
  logic [31:0] tie_line [5] = '{32'd6, 32'd0, 32'd0, 32'd0, 32'd0};
  // Two interleaved variables: negative tie on var 0, reversed extremes on var 1
  logic [31:0] mix_line [10] = '{32'hFFFF_FFFA, 32'h8000_0000, 32'd0, 32'h7FFF_FFFF,
                                 32'd0, 32'h8000_0000, 32'd0, 32'h7FFF_FFFF,
                                 32'd0, 32'h8000_0000};

  fourth_order_first_derivative_stencil dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  fods_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tlast    (out_tlast),
    .out_tuser    (out_tuser),
    .fail_count   (fail_count),
    .pending      (pending),
    .samples_seen (samples_seen),
    .derivs_seen  (derivs_seen),
    .lines_seen   (lines_seen)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still outstanding", cycles, pending);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver: mostly ready, short stalls, the odd long one; whole phases
  // run with no stall at all.
  always @(negedge clk) begin
    if (stall_off) begin
      out_tready <= 1'b1;
      ready_hold = 0;
    end else if (ready_hold > 0) begin
      ready_hold = ready_hold - 1;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 65) begin
        out_tready <= 1'b1;
        ready_hold = $urandom_range(0, 6);
      end else if (ready_roll < 94) begin
        out_tready <= 1'b0;
        ready_hold = $urandom_range(0, 2);
      end else begin
        out_tready <= 1'b0;
        ready_hold = $urandom_range(8, 40);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Bias toward full scale and small values so rounding ties and
  // extremes show up often.
  function automatic logic [31:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    case (r % 4)
      0: if (r < 12) return 32'h7FFF_FFFF;
      1: if (r < 12) return 32'h8000_0000;
      2: if (r < 12) return 32'hFFFF_FFFF;
      default: if (r < 12) return 32'd0;
    endcase
    if (r < 32) return 32'($signed($urandom_range(0, 200)) - 100);
    return $urandom;
  endfunction

  function automatic int eff_points(input logic [12:0] lp);
    if (lp < 13'd5) return 5;
    if (lp > 13'd4096) return 4096;
    return int'(lp);
  endfunction

  function automatic int eff_vars(input logic [3:0] nv);
    if (nv == 4'd0) return 1;
    if (nv > 4'd8) return 8;
    return int'(nv);
  endfunction

  // Call at a falling edge; return at the falling edge after the beat is taken.
  // tvalid stays high into the next call when no gap is drawn.
  task automatic send_sample(input logic [31:0] s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // Drop tvalid, wait until every expected result is out, then wait out
  // DRAIN_CYCLES more falling edges.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Call only while idle. One write per cycle; tvalid is already low.
  task automatic set_regs(input bit do_lp, input logic [12:0] lp,
                          input bit do_nv, input logic [12:0] nv);
    if (do_lp) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_LINE_POINTS;
      cfg_wdata <= lp;
      lp_shadow  = lp;
      @(negedge clk);
    end
    if (do_nv) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_NUM_VARS;
      cfg_wdata <= nv;
      nv_shadow  = nv;
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    // hold reset low, then release it at a falling edge
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: defaults (5 points, 1 variable), full-scale and tie lines
    no_idle = 1'b1;
    foreach (alt_line[i]) send_sample(alt_line[i]);
    no_idle = 1'b0;
    foreach (tie_line[i]) send_sample(tie_line[i]);

    // Clamp line_points up from 0, two interleaved variables
    settle();
    set_regs(1'b1, 13'd0, 1'b1, 13'd2);
    foreach (mix_line[i]) send_sample(mix_line[i]);

    // line_points written all ones clamps to 4096: run the head of that line
    settle();
    set_regs(1'b1, 13'h1FFF, 1'b1, 13'd1);
    repeat (30) send_sample(pick_sample());

    // Widest point: eight variables, one five-point line
    settle();
    set_regs(1'b1, 13'd5, 1'b1, 13'd8);
    repeat (40) send_sample(pick_sample());

    // Random phases: mostly whole lines, some cut short so the next write
    // restarts mid-line, some resumed without a write.
    while (items_sent < ITEM_TARGET) begin
      settle();
      no_idle   = ($urandom_range(0, 4) == 0);
      stall_off = ($urandom_range(0, 5) == 0);

      roll  = $urandom_range(0, 99);
      wr_lp = (roll < 70);
      wr_nv = (roll < 45) || (roll >= 70 && roll < 90);

      roll = $urandom_range(0, 99);
      if (roll < 70) lp_w = 13'($urandom_range(5, 12));
      else if (roll < 85) lp_w = 13'($urandom_range(13, 40));
      else if (roll < 93) lp_w = 13'($urandom_range(0, 4));
      else lp_w = 13'($urandom_range(4097, 8191));

      roll = $urandom_range(0, 99);
      if (roll < 60) nib = $urandom_range(1, 4);
      else if (roll < 85) nib = $urandom_range(5, 8);
      else begin
        nib = $urandom_range(8, 15);
        if (nib == 8) nib = 0;
      end
      // upper bits are junk the register must drop
      nv_w = {9'($urandom_range(0, 511)), 4'(nib)};

      set_regs(wr_lp, lp_w, wr_nv, nv_w);

      per_line = eff_points(lp_shadow) * eff_vars(nv_shadow[3:0]);
      if (per_line > 96 || $urandom_range(0, 3) == 0)
        beats_planned = $urandom_range(1, (per_line > 30) ? 30 : per_line - 1);
      else
        beats_planned = per_line * $urandom_range(1, 2);

      repeat (beats_planned) send_sample(pick_sample());
    end

    stall_off = 1'b0;
    settle();

    $display("%0d sample beats driven, %0d derivative beats checked, %0d lines closed",
             samples_seen, derivs_seen, lines_seen);
    $display("covered 1..8 variables, clamped line lengths, odd writes and mid-line restarts");
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
